// File: design/tpss_pkg.sv
// Shared types and constants for the triangle plane slice segment block.
package tpss_pkg;

   // Stages in one crossing lane: magnitude, multiply, 32 divide steps, result.
   localparam int COORD_W     = 32;
   localparam int LANE_LAT    = COORD_W + 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COORD_W:0]   diff_type;

   // One crossed edge: its start vertex and the differences the lanes need.
   typedef struct packed {
      coord_type ax;
      coord_type ay;
      diff_type  num;
      diff_type  den;
      diff_type  span_x;
      diff_type  span_y;
   } crossing_type;

   typedef struct packed {
      crossing_type seg_start;
      crossing_type seg_end;
   } job_type;

   // Status the queue gives to the front and back ends.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: design/tpss_front.sv
// Front end: classifies vertices against the plane and picks the two crossed edges.
module tpss_front (
   input  logic               req_valid,
   input  tpss_pkg::coord_type v0_x,
   input  tpss_pkg::coord_type v0_y,
   input  tpss_pkg::coord_type v0_z,
   input  tpss_pkg::coord_type v1_x,
   input  tpss_pkg::coord_type v1_y,
   input  tpss_pkg::coord_type v1_z,
   input  tpss_pkg::coord_type v2_x,
   input  tpss_pkg::coord_type v2_y,
   input  tpss_pkg::coord_type v2_z,
   input  tpss_pkg::coord_type height,
   input  tpss_pkg::queue_status_type status,
   output logic               req_stall,
   output logic               push,
   output tpss_pkg::job_type  job
);

   logic up0, up1, up2;
   logic e01, e12, e20;
   tpss_pkg::coord_type fa_x, fa_y, fa_z, fb_x, fb_y, fb_z;
   tpss_pkg::coord_type sa_x, sa_y, sa_z, sb_x, sb_y, sb_z;

   always_comb begin
      // A vertex on the plane counts as above it.
      up0 = (v0_z >= height);
      up1 = (v1_z >= height);
      up2 = (v2_z >= height);
      e01 = up0 ^ up1;
      e12 = up1 ^ up2;
      e20 = up2 ^ up0;

      fa_x = e01 ? v0_x : v1_x;
      fa_y = e01 ? v0_y : v1_y;
      fa_z = e01 ? v0_z : v1_z;
      fb_x = e01 ? v1_x : v2_x;
      fb_y = e01 ? v1_y : v2_y;
      fb_z = e01 ? v1_z : v2_z;

      sa_x = (e01 && e12) ? v1_x : v2_x;
      sa_y = (e01 && e12) ? v1_y : v2_y;
      sa_z = (e01 && e12) ? v1_z : v2_z;
      sb_x = (e01 && e12) ? v2_x : v0_x;
      sb_y = (e01 && e12) ? v2_y : v0_y;
      sb_z = (e01 && e12) ? v2_z : v0_z;

      job.seg_start.ax     = fa_x;
      job.seg_start.ay     = fa_y;
      job.seg_start.num    = 33'(height) - 33'(fa_z);
      job.seg_start.den    = 33'(fb_z) - 33'(fa_z);
      job.seg_start.span_x = 33'(fb_x) - 33'(fa_x);
      job.seg_start.span_y = 33'(fb_y) - 33'(fa_y);
      job.seg_end.ax       = sa_x;
      job.seg_end.ay       = sa_y;
      job.seg_end.num      = 33'(height) - 33'(sa_z);
      job.seg_end.den      = 33'(sb_z) - 33'(sa_z);
      job.seg_end.span_x   = 33'(sb_x) - 33'(sa_x);
      job.seg_end.span_y   = 33'(sb_y) - 33'(sa_y);

      // Triangles entirely on one side are accepted and dropped.
      req_stall = status.full;
      push      = req_valid && !status.full && (e01 || e12 || e20);
   end

endmodule

// File: design/tpss_queue.sv
// Short queue of classified items between the front and back ends.
module tpss_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tpss_pkg::job_type          push_job,
   input  logic                       pop,
   output tpss_pkg::job_type          head_job,
   output tpss_pkg::queue_status_type status
);

   tpss_pkg::job_type                  mem_ff [tpss_pkg::QUEUE_DEPTH];
   logic [tpss_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tpss_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tpss_pkg::QUEUE_PTR_W:0]     count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == (tpss_pkg::QUEUE_PTR_W+1)'(tpss_pkg::QUEUE_DEPTH));
      head_job     = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

// File: design/tpss_div.sv
// One crossing lane: a + trunc(num * span / den) as a pipelined multiply and divide.
module tpss_div (
   input  logic                clock,
   input  logic                en,
   input  tpss_pkg::coord_type a,
   input  tpss_pkg::diff_type  num,
   input  tpss_pkg::diff_type  span,
   input  tpss_pkg::diff_type  den,
   output tpss_pkg::coord_type res
);

   localparam int W = tpss_pkg::COORD_W;

   logic [W:0]   num_neg, span_neg, den_neg;
   logic [W-1:0] nm_in, sm_in, dm_in;
   logic [W-1:0] nm_ff, sm_ff, dm1_ff;
   logic         neg1_ff;
   tpss_pkg::coord_type a1_ff;

   logic [2*W-1:0] prod_ff;
   logic [W-1:0]   dm2_ff;
   logic           neg2_ff;
   tpss_pkg::coord_type a2_ff;

   // One restoring step per stage, one quotient bit each.
   logic [W-1:0]        rem_w [W+1];
   logic [W-1:0]        low_w [W+1];
   logic [W-1:0]        quo_w [W+1];
   logic [W-1:0]        dm_w  [W+1];
   logic                neg_w [W+1];
   tpss_pkg::coord_type a_w   [W+1];
   logic [W-1:0]        rem_ff [W];
   logic [W-1:0]        low_ff [W];
   logic [W-1:0]        quo_ff [W];
   logic [W-1:0]        dm_ff  [W];
   logic                neg_ff [W];
   tpss_pkg::coord_type a_ff   [W];
   tpss_pkg::coord_type res_ff;

   always_comb begin
      num_neg  = -num;
      span_neg = -span;
      den_neg  = -den;
      nm_in    = num[W]  ? num_neg[W-1:0]  : num[W-1:0];
      sm_in    = span[W] ? span_neg[W-1:0] : span[W-1:0];
      dm_in    = den[W]  ? den_neg[W-1:0]  : den[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff   <= nm_in;
         sm_ff   <= sm_in;
         dm1_ff  <= dm_in;
         neg1_ff <= num[W] ^ span[W] ^ den[W];
         a1_ff   <= a;
         prod_ff <= {{W{1'b0}}, nm_ff} * {{W{1'b0}}, sm_ff};
         dm2_ff  <= dm1_ff;
         neg2_ff <= neg1_ff;
         a2_ff   <= a1_ff;
      end
   end

   // The quotient never exceeds |span|, so the upper half is already below the divisor.
   assign rem_w[0] = prod_ff[2*W-1:W];
   assign low_w[0] = prod_ff[W-1:0];
   assign quo_w[0] = '0;
   assign dm_w[0]  = dm2_ff;
   assign neg_w[0] = neg2_ff;
   assign a_w[0]   = a2_ff;

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W:0] trial;
      logic       ge;

      always_comb begin
         trial = {rem_w[k], low_w[k][W-1]};
         ge    = (trial >= {1'b0, dm_w[k]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? W'(trial - {1'b0, dm_w[k]}) : trial[W-1:0];
            low_ff[k] <= {low_w[k][W-2:0], 1'b0};
            quo_ff[k] <= {quo_w[k][W-2:0], ge};
            dm_ff[k]  <= dm_w[k];
            neg_ff[k] <= neg_w[k];
            a_ff[k]   <= a_w[k];
         end
      end

      assign rem_w[k+1] = rem_ff[k];
      assign low_w[k+1] = low_ff[k];
      assign quo_w[k+1] = quo_ff[k];
      assign dm_w[k+1]  = dm_ff[k];
      assign neg_w[k+1] = neg_ff[k];
      assign a_w[k+1]   = a_ff[k];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= neg_w[W] ? a_w[W] - quo_w[W] : a_w[W] + quo_w[W];
      end
   end

   assign res = res_ff;

endmodule

// File: design/tpss_back.sv
// Back end: four crossing lanes in lockstep and the result valid pipeline.
module tpss_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tpss_pkg::job_type          head_job,
   input  tpss_pkg::queue_status_type status,
   output logic                       pop,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output tpss_pkg::coord_type        start_x,
   output tpss_pkg::coord_type        start_y,
   output tpss_pkg::coord_type        end_x,
   output tpss_pkg::coord_type        end_y
);

   logic [tpss_pkg::LANE_LAT-1:0] valid_ff, valid_in;
   logic                          adv;

   always_comb begin
      // The whole pipeline moves unless a finished item waits at the output.
      adv      = !valid_ff[tpss_pkg::LANE_LAT-1] || !rsp_stall;
      pop      = adv && !status.empty;
      valid_in = {valid_ff[tpss_pkg::LANE_LAT-2:0], !status.empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   tpss_div u_start_x (
      .clock (clock), .en (adv),
      .a     (head_job.seg_start.ax),
      .num   (head_job.seg_start.num),
      .span  (head_job.seg_start.span_x),
      .den   (head_job.seg_start.den),
      .res   (start_x)
   );

   tpss_div u_start_y (
      .clock (clock), .en (adv),
      .a     (head_job.seg_start.ay),
      .num   (head_job.seg_start.num),
      .span  (head_job.seg_start.span_y),
      .den   (head_job.seg_start.den),
      .res   (start_y)
   );

   tpss_div u_end_x (
      .clock (clock), .en (adv),
      .a     (head_job.seg_end.ax),
      .num   (head_job.seg_end.num),
      .span  (head_job.seg_end.span_x),
      .den   (head_job.seg_end.den),
      .res   (end_x)
   );

   tpss_div u_end_y (
      .clock (clock), .en (adv),
      .a     (head_job.seg_end.ay),
      .num   (head_job.seg_end.num),
      .span  (head_job.seg_end.span_y),
      .den   (head_job.seg_end.den),
      .res   (end_y)
   );

   assign rsp_valid = valid_ff[tpss_pkg::LANE_LAT-1];

endmodule

// File: design/triangle_plane_slice_segment.sv
// Top level of the triangle plane slice segment block.
// A crossing triangle is queued and then passes through the lane pipeline to rsp_valid.
// Throughput: one triangle per cycle while rsp_stall is low; each divider is pipelined one bit per stage.
// A four-item queue lets the input side keep taking items while the output is stalled, until it is full.
// Reset (synchronous) empties the queue and the pipeline and sets slice_height to zero.
module triangle_plane_slice_segment (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tpss_pkg::coord_type req_v0_x,
   input  tpss_pkg::coord_type req_v0_y,
   input  tpss_pkg::coord_type req_v0_z,
   input  tpss_pkg::coord_type req_v1_x,
   input  tpss_pkg::coord_type req_v1_y,
   input  tpss_pkg::coord_type req_v1_z,
   input  tpss_pkg::coord_type req_v2_x,
   input  tpss_pkg::coord_type req_v2_y,
   input  tpss_pkg::coord_type req_v2_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tpss_pkg::coord_type rsp_start_x,
   output tpss_pkg::coord_type rsp_start_y,
   output tpss_pkg::coord_type rsp_end_x,
   output tpss_pkg::coord_type rsp_end_y,
   input  logic                csr_wr_en,
   input  tpss_pkg::coord_type csr_wr_data
);

   // The plane level. The user must write it only while no item is in flight; the block does not enforce this.
   tpss_pkg::coord_type slice_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_height_ff <= '0;
      end else if (csr_wr_en) begin
         slice_height_ff <= csr_wr_data;
      end
   end

   tpss_pkg::queue_status_type status;
   tpss_pkg::job_type          push_job;
   tpss_pkg::job_type          head_job;
   logic                       push;
   logic                       pop;

   // The front end classifies each triangle in the cycle it arrives. Triangles
   // that do not cross the plane are taken and dropped; the rest are queued
   // with their two crossed edges already picked in edge order.
   tpss_front u_front (
      .req_valid (req_valid),
      .v0_x      (req_v0_x),
      .v0_y      (req_v0_y),
      .v0_z      (req_v0_z),
      .v1_x      (req_v1_x),
      .v1_y      (req_v1_y),
      .v1_z      (req_v1_z),
      .v2_x      (req_v2_x),
      .v2_y      (req_v2_y),
      .v2_z      (req_v2_z),
      .height    (slice_height_ff),
      .status    (status),
      .req_stall (req_stall),
      .push      (push),
      .job       (push_job)
   );

   tpss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   // The back end runs the four interpolations side by side. Its last stage is
   // the output register, so a stalled item holds there while the queue fills.
   tpss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .status    (status),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .start_x   (rsp_start_x),
      .start_y   (rsp_start_y),
      .end_x     (rsp_end_x),
      .end_y     (rsp_end_y)
   );

endmodule
